// ===== rtl/mia_pkg.sv =====
package mia_pkg;

	localparam int MAX_SAMPLES_DEF = 256;

	localparam int TIME_W  = 48;
	localparam int PN_W    = 31;
	localparam int BYTES_W = 16;
	localparam int RTT_W   = 32;
	localparam int CNT_W   = 32;
	localparam int BCNT_W  = 48;

	// shared divider operand widths
	localparam int DIV_NUM_W = 72;
	localparam int DIV_DEN_W = 64;

	// input queue between front and back
	localparam int QDEPTH = 2;

	// event codes
	localparam logic [1:0] FN_START = 2'd0;
	localparam logic [1:0] FN_SENT  = 2'd1;
	localparam logic [1:0] FN_ACKED = 2'd2;
	localparam logic [1:0] FN_LOST  = 2'd3;

	localparam logic [23:0] BITS_PER_SEC_K = 24'd8000000;

	typedef struct packed {
		logic [1:0]         func;
		logic [TIME_W-1:0]  time_now;
		logic [PN_W-1:0]    pkt_number;
		logic [BYTES_W-1:0] pkt_bytes;
		logic [RTT_W-1:0]   rtt_sample;
	} item_t;

	typedef struct packed {
		logic               all_done;
		logic [CNT_W-1:0]   packets_sent;
		logic [CNT_W-1:0]   packets_accounted;
		logic [BCNT_W-1:0]  lost_bytes;
		logic [BCNT_W-1:0]  throughput_bps;
		logic [BCNT_W-1:0]  send_rate_bps;
		logic [31:0]        mean_rtt;
		logic signed [31:0] rtt_growth_q16;
		logic [16:0]        loss_rate;
	} result_t;

	// decoded event class
	typedef struct packed {
		logic start;
		logic sent;
		logic acked;
		logic lost;
	} cls_t;

	typedef struct packed {
		cls_t  cls;
		item_t item;
	} cmd_t;

endpackage

// ===== rtl/mia_ram.sv =====
module mia_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/mia_div.sv =====
module mia_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mia_pkg::DIV_NUM_W-1:0] num,
	input  logic [mia_pkg::DIV_DEN_W-1:0] den,
	output logic                          done,
	output logic [mia_pkg::DIV_NUM_W-1:0] quo
);

	localparam int NW = mia_pkg::DIV_NUM_W;
	localparam int DW = mia_pkg::DIV_DEN_W;
	localparam int CW = $clog2(NW);

	logic [NW-1:0] sh_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   r2;
	logic [DW:0]   diff;
	logic          ge;

	// restoring division, one quotient bit a cycle
	assign r2   = {rem_q, sh_q[NW-1]};
	assign diff = r2 - {1'b0, den_q};
	assign ge   = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : r2[DW-1:0];
			sh_q  <= {sh_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;

endmodule

// ===== rtl/mia_front.sv =====
module mia_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  mia_pkg::item_t  item,
	output logic            q_valid,
	output mia_pkg::cmd_t   q_cmd,
	input  logic            q_pop
);

	localparam int PW = $clog2(mia_pkg::QDEPTH);

	mia_pkg::cmd_t ent_q [mia_pkg::QDEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [PW:0]   cnt_q;
	mia_pkg::cmd_t cmd_in;
	logic          do_push;
	logic          do_pop;

	// classify the event
	always_comb begin
		cmd_in.item      = item;
		cmd_in.cls.start = item.func == mia_pkg::FN_START;
		cmd_in.cls.sent  = item.func == mia_pkg::FN_SENT;
		cmd_in.cls.acked = item.func == mia_pkg::FN_ACKED;
		cmd_in.cls.lost  = item.func == mia_pkg::FN_LOST;
	end

	assign full    = cnt_q == (PW+1)'(mia_pkg::QDEPTH);
	assign q_valid = cnt_q != '0;
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;
	assign q_cmd   = ent_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(mia_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(mia_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wptr_q] <= cmd_in;
		end
	end

endmodule

// ===== rtl/mia_back.sv =====
module mia_back #(
	parameter int MAX_SAMPLES = mia_pkg::MAX_SAMPLES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  mia_pkg::cmd_t    q_cmd,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output mia_pkg::result_t result
);

	localparam int AW   = $clog2(MAX_SAMPLES);
	localparam int SC_W = $clog2(MAX_SAMPLES + 1);
	localparam int PS_W = 32 + AW;
	localparam int TW   = mia_pkg::TIME_W;
	localparam int NW   = mia_pkg::DIV_NUM_W;
	localparam int DW   = mia_pkg::DIV_DEN_W;

	localparam logic [23:0] BITS_K = mia_pkg::BITS_PER_SEC_K;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_UPD  = 10'b0000000010,
		ST_RDA  = 10'b0000000100,
		ST_RDB  = 10'b0000001000,
		ST_RDC  = 10'b0000010000,
		ST_MUL  = 10'b0000100000,
		ST_OPS  = 10'b0001000000,
		ST_DIV  = 10'b0010000000,
		ST_DONE = 10'b0100000000,
		ST_WAIT = 10'b1000000000
	} state_t;

	typedef enum logic [2:0] {
		JB_LOSS = 3'd0,
		JB_THR  = 3'd1,
		JB_SND  = 3'd2,
		JB_MEAN = 3'd3,
		JB_INF  = 3'd4
	} job_t;

	state_t state_q;
	job_t   job_q;

	mia_pkg::cmd_t cmd_q;

	logic [TW-1:0]    iend_q, fst_q, lst_q, fat_q, lat_q;
	logic [30:0]      fnum_q, lnum_q;
	logic [31:0]      lan_q;
	logic [31:0]      scnt_q, acnt_q;
	logic [47:0]      sbytes_q, abytes_q, dbytes_q;
	logic [SC_W-1:0]  sc_q;
	logic [PS_W-1:0]  sum_last_q;
	logic             done_flag_q;

	logic [PS_W-1:0]  p1_q, p2_q, mag_q;
	logic             neg_q;
	logic [47:0]      plo_q, phi_q;
	logic [DW-1:0]    den_mul_q;

	logic [16:0]      loss_q;
	logic [47:0]      thr_q, snd_q;
	logic [31:0]      mean_q, inf_q;

	mia_pkg::result_t out_q;
	logic             out_valid_q;

	// ram
	logic             ram_we;
	logic [AW-1:0]    ram_raddr;
	logic [PS_W-1:0]  ram_rdata;
	logic [PS_W-1:0]  new_sum;

	// divider
	logic             div_start;
	logic [NW-1:0]    div_num;
	logic [DW-1:0]    div_den;
	logic             div_done;
	logic [NW-1:0]    div_quo;

	// event fields
	logic [TW-1:0]    t;
	logic [30:0]      pn;
	logic [15:0]      bytes;
	logic [31:0]      rtt;

	assign t     = cmd_q.item.time_now;
	assign pn    = cmd_q.item.pkt_number;
	assign bytes = cmd_q.item.pkt_bytes;
	assign rtt   = cmd_q.item.rtt_sample;

	// ack / loss classification
	logic              in_span, newer, beyond, take;
	logic signed [32:0] pn_s, lan_s;
	logic [32:0]       step;
	logic [33:0]       acc_sum;
	logic [31:0]       acc_sat;
	logic [48:0]       ab_sum, db_sum, sb_sum;
	logic [32:0]       sc_sum;
	logic              room;
	logic [TW-1:0]     lat_new;

	assign pn_s    = $signed({2'b00, pn});
	assign lan_s   = $signed({lan_q[31], lan_q});
	assign in_span = pn >= fnum_q && pn <= lnum_q;
	assign newer   = pn_s > lan_s;
	assign beyond  = pn > lnum_q;
	assign take    = in_span && newer;
	assign step    = 33'(pn_s - lan_s);
	assign acc_sum = {2'b00, acnt_q} + {1'b0, step};
	assign acc_sat = |acc_sum[33:32] ? 32'hFFFF_FFFF : acc_sum[31:0];
	assign ab_sum  = {1'b0, abytes_q} + 49'(bytes);
	assign db_sum  = {1'b0, dbytes_q} + 49'(bytes);
	assign sb_sum  = {1'b0, sbytes_q} + 49'(bytes);
	assign sc_sum  = {1'b0, scnt_q} + 33'd1;
	assign room    = sc_q < SC_W'(MAX_SAMPLES);
	assign new_sum = sum_last_q + PS_W'(rtt);
	assign ram_we  = state_q == ST_UPD && cmd_q.cls.acked && take && room;

	always_comb begin
		lat_new = (take && cmd_q.cls.acked) ? t : lat_q;
		if (pn >= lnum_q && lat_new == '0) begin
			lat_new = t;
		end
	end

	// derived quantities
	logic [SC_W-2:0] half;
	logic            send_ok, ack_ok;
	logic [TW-1:0]   send_span, ack_dur;
	logic [PS_W-1:0] s2v;

	assign half      = sc_q[SC_W-1:1];
	assign send_ok   = lst_q > fst_q;
	assign ack_ok    = lat_q > fat_q;
	assign send_span = lst_q - fst_q;
	assign ack_dur   = lat_q - fat_q;
	assign s2v       = p2_q - p1_q;

	always_comb begin
		ram_raddr = AW'(half) - 1'b1;
		if (state_q == ST_RDB) begin
			ram_raddr = AW'({half, 1'b0}) - 1'b1;
		end
	end

	mia_ram #(
		.WIDTH(PS_W),
		.DEPTH(MAX_SAMPLES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sc_q[AW-1:0]),
		.wdata (new_sum),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// operand selection for the shared divider
	assign div_start = state_q == ST_OPS;

	always_comb begin
		div_num = '0;
		div_den = '0;
		case (job_q)
			JB_LOSS: begin
				div_num = NW'({sbytes_q - abytes_q, 16'd0});
				div_den = DW'(sbytes_q);
			end
			JB_THR, JB_SND: begin
				div_num = (NW'(phi_q) << 24) + NW'(plo_q);
				div_den = DW'(job_q == JB_THR ? ack_dur : send_span);
			end
			JB_MEAN: begin
				div_num = NW'(sum_last_q);
				div_den = DW'(sc_q);
			end
			JB_INF: begin
				div_num = NW'({mag_q, 16'd0});
				div_den = den_mul_q;
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	mia_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// quotient post-processing
	logic [16:0] loss_v;
	logic [47:0] rate_v;
	logic [31:0] inf_v;

	always_comb begin
		if (sbytes_q == '0 || abytes_q >= sbytes_q) begin
			loss_v = '0;
		end else if (|div_quo[NW-1:17] || (div_quo[16] && |div_quo[15:0])) begin
			loss_v = 17'h10000;
		end else begin
			loss_v = div_quo[16:0];
		end
		rate_v = |div_quo[NW-1:48] ? 48'hFFFF_FFFF_FFFF : div_quo[47:0];
		if (sc_q < SC_W'(2) || !send_ok) begin
			inf_v = '0;
		end else if (neg_q) begin
			if (|div_quo[NW-1:32] || (div_quo[31] && |div_quo[30:0])) begin
				inf_v = 32'h8000_0000;
			end else begin
				inf_v = 32'd0 - div_quo[31:0];
			end
		end else begin
			inf_v = |div_quo[NW-1:31] ? 32'h7FFF_FFFF : div_quo[31:0];
		end
	end

	assign q_pop = state_q == ST_IDLE && q_valid;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= JB_LOSS;
			out_valid_q <= 1'b0;
			iend_q      <= '0;
			fst_q       <= '0;
			lst_q       <= '0;
			fnum_q      <= '0;
			lnum_q      <= '0;
			lan_q       <= '1;
			scnt_q      <= '0;
			acnt_q      <= '0;
			sbytes_q    <= '0;
			abytes_q    <= '0;
			dbytes_q    <= '0;
			fat_q       <= '0;
			lat_q       <= '0;
			sc_q        <= '0;
			sum_last_q  <= '0;
			done_flag_q <= 1'b0;
		end else begin
			// the result register is refilled in ST_WAIT, otherwise a pop drains it
			if (pop && out_valid_q && state_q != ST_WAIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					state_q <= ST_RDA;
					if (cmd_q.cls.start) begin
						iend_q      <= t;
						fst_q       <= '0;
						lst_q       <= '0;
						fnum_q      <= '0;
						lnum_q      <= '0;
						lan_q       <= '1;
						scnt_q      <= '0;
						acnt_q      <= '0;
						sbytes_q    <= '0;
						abytes_q    <= '0;
						dbytes_q    <= '0;
						fat_q       <= '0;
						lat_q       <= '0;
						sc_q        <= '0;
						sum_last_q  <= '0;
						done_flag_q <= 1'b1;
					end else if (cmd_q.cls.sent) begin
						if (scnt_q == '0) begin
							fst_q  <= t;
							fnum_q <= pn;
							lan_q  <= {1'b0, pn} - 32'd1;
						end
						lst_q       <= t;
						lnum_q      <= pn;
						scnt_q      <= sc_sum[32] ? 32'hFFFF_FFFF : sc_sum[31:0];
						sbytes_q    <= sb_sum[48] ? 48'hFFFF_FFFF_FFFF : sb_sum[47:0];
						done_flag_q <= t >= iend_q &&
							acnt_q == (sc_sum[32] ? 32'hFFFF_FFFF : sc_sum[31:0]);
					end else begin
						if (take) begin
							acnt_q <= acc_sat;
							lan_q  <= {1'b0, pn};
							if (cmd_q.cls.acked) begin
								abytes_q <= ab_sum[48] ? 48'hFFFF_FFFF_FFFF : ab_sum[47:0];
								if (room) begin
									sum_last_q <= new_sum;
									sc_q       <= sc_q + 1'b1;
								end
							end else begin
								dbytes_q <= db_sum[48] ? 48'hFFFF_FFFF_FFFF : db_sum[47:0];
							end
						end else if (beyond) begin
							acnt_q <= scnt_q;
							lan_q  <= {1'b0, lnum_q};
						end
						if (pn >= fnum_q && fat_q == '0) begin
							fat_q <= t;
						end
						lat_q       <= lat_new;
						done_flag_q <= t >= iend_q &&
							(take ? acc_sat : (beyond ? scnt_q : acnt_q)) == scnt_q;
					end
				end
				ST_RDA: state_q <= ST_RDB;
				ST_RDB: state_q <= ST_RDC;
				ST_RDC: begin
					state_q <= ST_MUL;
					job_q   <= JB_LOSS;
				end
				ST_MUL: state_q <= ST_OPS;
				ST_OPS: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						if (job_q == JB_INF) begin
							state_q <= ST_DONE;
						end else begin
							job_q   <= job_t'(job_q + 3'd1);
							state_q <= ST_MUL;
						end
					end
				end
				ST_DONE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (!out_valid_q || pop) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == ST_RDB) begin
			p1_q <= ram_rdata;
		end
		if (state_q == ST_RDC) begin
			p2_q <= ram_rdata;
		end
		if (state_q == ST_MUL) begin
			// partial products of bytes times 8e6
			plo_q     <= (job_q == JB_THR ? abytes_q[23:0] : sbytes_q[23:0]) * BITS_K;
			phi_q     <= (job_q == JB_THR ? abytes_q[47:24] : sbytes_q[47:24]) * BITS_K;
			den_mul_q <= DW'(half) * DW'(send_span);
			neg_q     <= s2v < p1_q;
			mag_q     <= (s2v < p1_q) ? p1_q - s2v : s2v - p1_q;
		end
		if (state_q == ST_DIV && div_done) begin
			case (job_q)
				JB_LOSS: loss_q <= loss_v;
				JB_THR:  thr_q  <= ack_ok ? rate_v : '0;
				JB_SND:  snd_q  <= send_ok ? rate_v : '0;
				JB_MEAN: mean_q <= sc_q == '0 ? '0 : div_quo[31:0];
				JB_INF:  inf_q  <= inf_v;
				default: loss_q <= loss_v;
			endcase
		end
		if (state_q == ST_WAIT && (!out_valid_q || pop)) begin
			out_q.all_done          <= done_flag_q;
			out_q.packets_sent      <= scnt_q;
			out_q.packets_accounted <= acnt_q;
			out_q.lost_bytes        <= dbytes_q;
			out_q.throughput_bps    <= thr_q;
			out_q.send_rate_bps     <= snd_q;
			out_q.mean_rtt          <= mean_q;
			out_q.rtt_growth_q16    <= $signed(inf_q);
			out_q.loss_rate         <= loss_q;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

// ===== rtl/monitor_interval_accounting_core.sv =====
// Monitor interval accounting. Events (start, sent, acked, lost) are pushed
// into a two-word queue and handled one at a time; every event yields one
// result word holding the interval counters and derived statistics. In the
// back end an event passes through the queue pop, the state update and two
// prefix-sum reads, then five statistics (loss rate, throughput, send rate,
// mean RTT, RTT inflation) each go through one shared restoring divider that
// makes one quotient bit a cycle over a 72-bit dividend and then flags
// completion, after a setup step that forms the products and one that starts
// the divider; ST_DONE and ST_WAIT then hand the word to the result register.
// The back end holds in ST_WAIT while an earlier word still waits unpopped.
// Pushes are still taken while the back end works, until the queue is full,
// and a finished result waits in its own register until it is popped.
module monitor_interval_accounting_core #(
	parameter int MAX_SAMPLES = mia_pkg::MAX_SAMPLES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// event side
	input  logic             push,
	output logic             full,
	input  mia_pkg::item_t   item,
	// result side
	output logic             empty,
	input  logic             pop,
	output mia_pkg::result_t result
);

	// queue between front (classify) and back (update and statistics)
	logic          q_valid;
	logic          q_pop;
	mia_pkg::cmd_t q_cmd;

	mia_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop)
	);

	// back end: interval state, rtt prefix-sum store, divider sequencing
	mia_back #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
